[hw/rtl/tphc_pkg.sv]
// Package for the transport pseudo-header checksum core.
// Holds field widths, register indexes, protocol constants and checksum helpers.
// No dependencies.
`default_nettype none

package tphc_pkg;

  // Field widths
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IP_VERSION_SIX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRANSPORT_IS_UDP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ADDR_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_ADDR_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_ADDR_HIGH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_ADDR_LOW    = 3'd5;

  // Protocol numbers, checksum field offsets, minimum header lengths
  localparam logic [WORD_W-1:0] PROTO_TCP = 16'd6;
  localparam logic [WORD_W-1:0] PROTO_UDP = 16'd17;
  localparam int unsigned CKS_OFF_TCP = 16;
  localparam int unsigned CKS_OFF_UDP = 6;
  localparam int unsigned MIN_LEN_TCP = 20;
  localparam int unsigned MIN_LEN_UDP = 8;

  localparam int unsigned DEF_MAX_SEG_BYTES = 65535;

  // Ones'-complement add of two words with end-around carry
  function automatic logic [WORD_W-1:0] oc_add(input logic [WORD_W-1:0] a,
                                               input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    logic [WORD_W:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = {1'b0, s[WORD_W-1:0]} + {{WORD_W{1'b0}}, s[WORD_W]};
    return f[WORD_W-1:0];
  endfunction

  // Ones'-complement sum of the four 16-bit words of a 64-bit value
  function automatic logic [WORD_W-1:0] oc_fold64(input logic [CFG_W-1:0] v);
    logic [WORD_W+1:0] s;
    logic [WORD_W:0]   f1;
    logic [WORD_W:0]   f2;
    s  = 18'(v[63:48]) + 18'(v[47:32]) + 18'(v[31:16]) + 18'(v[15:0]);
    f1 = 17'(s[WORD_W-1:0]) + 17'(s[WORD_W+1:WORD_W]);
    f2 = 17'(f1[WORD_W-1:0]) + 17'(f1[WORD_W]);
    return f2[WORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/tphc_if.sv]
// Stream interfaces of the transport pseudo-header checksum core.
// Input channel carries segment bytes, output channel carries results.
// Depends on tphc_pkg.
`default_nettype none

interface tphc_in_if;
  logic                        valid;
  logic                        ready;
  logic [tphc_pkg::DATA_W-1:0] data_byte;
  logic                        last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface tphc_out_if;
  logic                        valid;
  logic                        ready;
  logic [tphc_pkg::WORD_W-1:0] checksum_value;
  logic [tphc_pkg::WORD_W-1:0] segment_length;
  logic                        too_short;
  logic                        too_long;

  modport source (output valid, checksum_value, segment_length, too_short, too_long,
                  input ready);
  modport sink   (input valid, checksum_value, segment_length, too_short, too_long,
                  output ready);
endinterface

`default_nettype wire

[hw/rtl/transport_pseudo_header_checksum_core.sv]
// Top level of the TCP/UDP pseudo-header checksum core.
// Depends on tphc_pkg and the stream interfaces in tphc_if.sv.
//
//   channel  | dir | payload                                          | handshake
//   ---------+-----+--------------------------------------------------+-------------
//   in_i     | in  | data_byte, last_byte                             | valid/ready
//   out_o    | out | checksum_value, segment_length, too_short, too_long | valid/ready
//   cfg      | in  | cfg_idx_i, cfg_wdata_i                           | cfg_we_i
//
// One byte is taken per cycle unless stalled. The segment stage folds the last byte into
// the pending register; the finish stage then adds the pseudo-header into the output
// register. Both stages stall together when the output register is full and not taken.
// Reset clears configuration, the running segment state and both valid flags.
`default_nettype none

module transport_pseudo_header_checksum_core #(
  parameter int unsigned MaxSegmentBytes = tphc_pkg::DEF_MAX_SEG_BYTES
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [tphc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire [tphc_pkg::CFG_W-1:0]       cfg_wdata_i,
  tphc_in_if.sink                         in_i,
  tphc_out_if.source                      out_o
);
  import tphc_pkg::*;

  localparam int unsigned    CntW     = $clog2(MaxSegmentBytes + 2);
  localparam logic [CntW-1:0] CntSat  = CntW'(MaxSegmentBytes + 1);
  localparam logic [WORD_W-1:0] MaxSeg = WORD_W'(MaxSegmentBytes);

  // Configuration registers and per-register word sums
  // IPv4 uses only the low 32 bits of the low address registers
  logic                ip6_q, udp_q;
  logic [2*WORD_W-1:0] src_lo_q, dst_lo_q;
  logic [WORD_W-1:0]   src_hi_ps_q, src_lo_ps_q, dst_hi_ps_q, dst_lo_ps_q;
  logic [WORD_W-1:0]   wdata_ps;

  assign wdata_ps = oc_fold64(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ip6_q       <= 1'b0;
      udp_q       <= 1'b0;
      src_lo_q    <= '0;
      dst_lo_q    <= '0;
      src_hi_ps_q <= '0;
      src_lo_ps_q <= '0;
      dst_hi_ps_q <= '0;
      dst_lo_ps_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IP_VERSION_SIX:   ip6_q <= cfg_wdata_i[0];
        CFG_TRANSPORT_IS_UDP: udp_q <= cfg_wdata_i[0];
        CFG_SOURCE_ADDR_HIGH: begin
          src_hi_ps_q <= wdata_ps;
        end
        CFG_SOURCE_ADDR_LOW: begin
          src_lo_q    <= cfg_wdata_i[2*WORD_W-1:0];
          src_lo_ps_q <= wdata_ps;
        end
        CFG_DEST_ADDR_HIGH: begin
          dst_hi_ps_q <= wdata_ps;
        end
        CFG_DEST_ADDR_LOW: begin
          dst_lo_q    <= cfg_wdata_i[2*WORD_W-1:0];
          dst_lo_ps_q <= wdata_ps;
        end
        default: ;
      endcase
    end
  end

  // Handshake: both stages move whenever the output register can take a result
  logic out_valid_q;
  logic advance;
  logic accept;

  assign advance    = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;
  assign accept     = in_i.valid && advance;

  // Segment stage: running sum, byte count and held high byte
  logic [WORD_W-1:0] sum_q;
  logic [CntW-1:0]   cnt_q;
  logic [DATA_W-1:0] held_q;
  logic              odd_q;

  logic [CntW-1:0]   cks_at;
  logic              cks_byte;
  logic [DATA_W-1:0] byte_eff;
  logic [CntW-1:0]   cnt_inc;
  logic [WORD_W-1:0] add_word;
  logic [WORD_W-1:0] add_sum;

  always_comb begin
    cks_at   = udp_q ? CntW'(CKS_OFF_UDP) : CntW'(CKS_OFF_TCP);
    cks_byte = (cnt_q == cks_at) || (cnt_q == cks_at + CntW'(1));
    byte_eff = cks_byte ? '0 : in_i.data_byte;
    cnt_inc  = (cnt_q != CntSat) ? cnt_q + CntW'(1) : cnt_q;
    // A lone final byte is padded with a zero low byte
    add_word = odd_q ? {held_q, byte_eff} : {byte_eff, 8'h00};
    add_sum  = oc_add(sum_q, add_word);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      cnt_q  <= '0;
      held_q <= '0;
      odd_q  <= 1'b0;
    end else if (accept) begin
      if (in_i.last_byte) begin
        sum_q  <= '0;
        cnt_q  <= '0;
        held_q <= '0;
        odd_q  <= 1'b0;
      end else begin
        cnt_q <= cnt_inc;
        if (odd_q) begin
          sum_q  <= add_sum;
          held_q <= '0;
          odd_q  <= 1'b0;
        end else begin
          held_q <= byte_eff;
          odd_q  <= 1'b1;
        end
      end
    end
  end

  // Pending result: data sum and count of a finished segment
  logic              pend_valid_q;
  logic [WORD_W-1:0] pend_sum_q;
  logic [CntW-1:0]   pend_cnt_q;
  logic              pend_udp_q;
  logic              pend_ip6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (advance) begin
      pend_valid_q <= accept && in_i.last_byte;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_i.last_byte) begin
      pend_sum_q <= add_sum;
      pend_cnt_q <= cnt_inc;
      pend_udp_q <= udp_q;
      pend_ip6_q <= ip6_q;
    end
  end

  // Finish stage: add pseudo-header words in one adder, then fold twice
  logic              too_long;
  logic              too_short;
  logic [WORD_W-1:0] seg_len;
  logic [WORD_W-1:0] proto;
  logic [WORD_W-1:0] t_a, t_b, t_c, t_d;
  logic [WORD_W+2:0] total;
  logic [WORD_W:0]   fold1;
  logic [WORD_W:0]   fold2;

  always_comb begin
    too_long  = (pend_cnt_q == CntSat);
    seg_len   = too_long ? MaxSeg : WORD_W'(pend_cnt_q);
    too_short = pend_udp_q ? (pend_cnt_q < CntW'(MIN_LEN_UDP))
                           : (pend_cnt_q < CntW'(MIN_LEN_TCP));
    proto     = pend_udp_q ? PROTO_UDP : PROTO_TCP;
    if (pend_ip6_q) begin
      t_a = src_hi_ps_q;
      t_b = src_lo_ps_q;
      t_c = dst_hi_ps_q;
      t_d = dst_lo_ps_q;
    end else begin
      t_a = src_lo_q[31:16];
      t_b = src_lo_q[15:0];
      t_c = dst_lo_q[31:16];
      t_d = dst_lo_q[15:0];
    end
    total = 19'(pend_sum_q) + 19'(proto) + 19'(seg_len)
          + 19'(t_a) + 19'(t_b) + 19'(t_c) + 19'(t_d);
    fold1 = 17'(total[WORD_W-1:0]) + 17'(total[WORD_W+2:WORD_W]);
    fold2 = 17'(fold1[WORD_W-1:0]) + 17'(fold1[WORD_W]);
  end

  // Output register
  logic [WORD_W-1:0] cks_q;
  logic [WORD_W-1:0] len_q;
  logic              short_q;
  logic              long_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= pend_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && pend_valid_q) begin
      cks_q   <= ~fold2[WORD_W-1:0];
      len_q   <= seg_len;
      short_q <= too_short;
      long_q  <= too_long;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.checksum_value = cks_q;
  assign out_o.segment_length = len_q;
  assign out_o.too_short      = short_q;
  assign out_o.too_long       = long_q;

endmodule

`default_nettype wire

[bench/tphc_checksum_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the transport pseudo-header checksum core: mirrors the register file
// and the segment sum, predicts each result and compares it field by field.
// Depends on tphc_pkg and the stream interfaces in tphc_if.sv.

module tphc_checksum_checker #(
  parameter int unsigned MaxSegmentBytes = tphc_pkg::DEF_MAX_SEG_BYTES
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_we_i,
  input  wire [tphc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire [tphc_pkg::CFG_W-1:0]     cfg_wdata_i,
  tphc_in_if                            in_mon,
  tphc_out_if                           out_mon,
  output int                            fail_count_o,
  output int                            pending_o
);
  import tphc_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] checksum_value;
    logic [WORD_W-1:0] segment_length;
    logic              too_short;
    logic              too_long;
  } seg_result_t;

  seg_result_t expected_results[$];
  int          mismatches = 0;
  int          outstanding = 0;

  // register mirror
  logic              is_v6;
  logic              is_udp;
  logic [CFG_W-1:0]  src_hi;
  logic [CFG_W-1:0]  src_lo;
  logic [CFG_W-1:0]  dst_hi;
  logic [CFG_W-1:0]  dst_lo;

  // segment state
  logic [WORD_W-1:0] seg_sum;
  logic [16:0]       seg_bytes;
  logic [DATA_W-1:0] held_hi;
  logic              half_word;

  assign fail_count_o = mismatches;
  assign pending_o    = outstanding;

  // 16-bit ones'-complement add with end-around carry
  function automatic logic [WORD_W-1:0] ones_add(input logic [WORD_W-1:0] a,
                                                 input logic [WORD_W-1:0] b);
    logic [WORD_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, s[WORD_W]};
  endfunction

  // adds the four words of a 64-bit value, most significant first
  function automatic logic [WORD_W-1:0] add_quad(input logic [WORD_W-1:0] acc,
                                                 input logic [CFG_W-1:0]  v);
    logic [WORD_W-1:0] r;
    int                k;
    r = acc;
    for (k = 3; k >= 0; k--) r = ones_add(r, v[16*k +: 16]);
    return r;
  endfunction

  task automatic clear_segment();
    seg_sum   = '0;
    seg_bytes = '0;
    held_hi   = '0;
    half_word = 1'b0;
  endtask

  // fold one accepted byte; on the last byte queue the expected result
  task automatic take_segment_byte(input logic [DATA_W-1:0] data, input logic last);
    logic [DATA_W-1:0] b;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] seg_len;
    logic              over;
    int unsigned       cks_at;
    int unsigned       min_len;
    seg_result_t       r;
    b      = data;
    cks_at = is_udp ? CKS_OFF_UDP : CKS_OFF_TCP;
    // checksum field reads as zero
    if (seg_bytes == cks_at || seg_bytes == cks_at + 1) b = '0;
    if (seg_bytes <= MaxSegmentBytes) seg_bytes++;
    if (half_word) begin
      seg_sum   = ones_add(seg_sum, {held_hi, b});
      held_hi   = '0;
      half_word = 1'b0;
    end else begin
      held_hi   = b;
      half_word = 1'b1;
    end
    if (last) begin
      sum = seg_sum;
      if (half_word) sum = ones_add(sum, {held_hi, 8'h00});
      over    = seg_bytes > MaxSegmentBytes;
      seg_len = over ? WORD_W'(MaxSegmentBytes) : seg_bytes[WORD_W-1:0];
      // pseudo-header
      if (is_v6) begin
        sum = add_quad(sum, src_hi);
        sum = add_quad(sum, src_lo);
        sum = add_quad(sum, dst_hi);
        sum = add_quad(sum, dst_lo);
      end else begin
        sum = add_quad(sum, {src_lo[31:0], dst_lo[31:0]});
      end
      sum     = ones_add(sum, is_udp ? PROTO_UDP : PROTO_TCP);
      sum     = ones_add(sum, seg_len);
      min_len = is_udp ? MIN_LEN_UDP : MIN_LEN_TCP;
      r.checksum_value = ~sum;
      r.segment_length = seg_len;
      r.too_short      = seg_bytes < min_len;
      r.too_long       = over;
      expected_results.push_back(r);
      clear_segment();
    end
  endtask

  task automatic check_result();
    seg_result_t want;
    if (expected_results.size() == 0) begin
      $error("result with no expectation: checksum_value %h", out_mon.checksum_value);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (out_mon.checksum_value !== want.checksum_value) begin
        $error("checksum_value: expected %h, actual %h", want.checksum_value,
               out_mon.checksum_value);
        mismatches++;
      end
      if (out_mon.segment_length !== want.segment_length) begin
        $error("segment_length: expected %0d, actual %0d", want.segment_length,
               out_mon.segment_length);
        mismatches++;
      end
      if (out_mon.too_short !== want.too_short) begin
        $error("too_short: expected %b, actual %b", want.too_short, out_mon.too_short);
        mismatches++;
      end
      if (out_mon.too_long !== want.too_long) begin
        $error("too_long: expected %b, actual %b", want.too_long, out_mon.too_long);
        mismatches++;
      end
    end
  endtask

  // sample all channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      is_v6  = 1'b0;
      is_udp = 1'b0;
      src_hi = '0;
      src_lo = '0;
      dst_hi = '0;
      dst_lo = '0;
      clear_segment();
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_IP_VERSION_SIX:   is_v6  = cfg_wdata_i[0];
          CFG_TRANSPORT_IS_UDP: is_udp = cfg_wdata_i[0];
          CFG_SOURCE_ADDR_HIGH: src_hi = cfg_wdata_i;
          CFG_SOURCE_ADDR_LOW:  src_lo = cfg_wdata_i;
          CFG_DEST_ADDR_HIGH:   dst_hi = cfg_wdata_i;
          CFG_DEST_ADDR_LOW:    dst_lo = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) take_segment_byte(in_mon.data_byte, in_mon.last_byte);
    end
    outstanding = expected_results.size();
  end

endmodule

[bench/tb_transport_pseudo_header_checksum_core.sv]
`timescale 1ns / 1ps
// Testbench top for the transport pseudo-header checksum core: drives segments and
// register writes with random idling and gives the verdict.
// Depends on tphc_pkg, tphc_if.sv, the core and tphc_checksum_checker.

module tb_transport_pseudo_header_checksum_core;
  import tphc_pkg::*;

  localparam int unsigned IDLE_MAX     = 12;
  localparam int unsigned RANDOM_BYTES = 1200;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned LATENCY      = 2;

  typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_e;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni    = 1'b0;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int          fail_count;
  int          pending_results;
  bit          send_calm   = 1'b0;
  bit          take_calm   = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned bytes_sent   = 0;

  tphc_in_if  in_if ();
  tphc_out_if out_if ();

  transport_pseudo_header_checksum_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  tphc_checksum_checker cks_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: ends the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, IDLE_MAX);
  endfunction

  function automatic logic [CFG_W-1:0] pick_addr();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // result side: random stall before each item, with calm stretches
  initial begin
    int unsigned stall;
    out_if.ready = 1'b0;
    forever begin
      if ($urandom_range(0, 24) == 0) take_calm = !take_calm;
      stall = draw_wait(take_calm);
      @(negedge clk_i);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  task automatic push_byte(input logic [DATA_W-1:0] b, input logic last);
    int unsigned gap;
    gap = draw_wait(send_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= last;
    do @(posedge clk_i); while (!in_if.ready);
    bytes_sent++;
  endtask

  task automatic send_segment(input int unsigned len, input fill_e fill, input bit close);
    logic [DATA_W-1:0] b;
    int unsigned       i;
    for (i = 0; i < len; i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom);
      endcase
      push_byte(b, close && (i == len - 1));
    end
  endtask

  // stop sending and wait until every expected result is in
  task automatic settle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results != 0) @(negedge clk_i);
    repeat (LATENCY + 2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input bit v6, input bit udp,
                            input logic [CFG_W-1:0] sh, input logic [CFG_W-1:0] sl,
                            input logic [CFG_W-1:0] dh, input logic [CFG_W-1:0] dl);
    write_reg(CFG_IP_VERSION_SIX, CFG_W'(v6));
    write_reg(CFG_TRANSPORT_IS_UDP, CFG_W'(udp));
    write_reg(CFG_SOURCE_ADDR_HIGH, sh);
    write_reg(CFG_SOURCE_ADDR_LOW, sl);
    write_reg(CFG_DEST_ADDR_HIGH, dh);
    write_reg(CFG_DEST_ADDR_LOW, dl);
  endtask

  // mostly short segments, some around the minimum header lengths, a few longer
  function automatic int unsigned pick_length();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(6, 9);
      1:       return $urandom_range(16, 21);
      2:       return $urandom_range(31, 90);
      default: return $urandom_range(1, 30);
    endcase
  endfunction

  function automatic fill_e pick_fill();
    case ($urandom_range(0, 11))
      0:       return FILL_ZERO;
      1:       return FILL_ONES;
      default: return FILL_RANDOM;
    endcase
  endfunction

  initial begin
    int unsigned random_start;
    int unsigned len;
    int unsigned cut;
    int unsigned nseg;
    fill_e       fill;

    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values: one odd byte, short TCP segment over IPv4
    push_byte(8'hFF, 1'b1);
    settle();

    // IPv6 TCP, all-ones addresses and data: heavy carries, checksum field zeroed
    set_config(1'b1, 1'b0, '1, '1, '1, '1);
    send_segment(20, FILL_ONES, 1'b1);
    settle();

    // UDP whose checksum comes out zero and stays zero
    set_config(1'b0, 1'b1, '0, '0, '0, '0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hE6, 1'b0);
    send_segment(4, FILL_ZERO, 1'b0);
    push_byte(8'hAB, 1'b0);
    push_byte(8'hCD, 1'b1);
    // short UDP segment
    send_segment(7, FILL_RANDOM, 1'b1);
    settle();

    // transport switched from UDP to TCP in the middle of a segment
    write_reg(CFG_SOURCE_ADDR_LOW, pick_addr());
    send_segment(5, FILL_RANDOM, 1'b0);
    settle();
    write_reg(CFG_TRANSPORT_IS_UDP, CFG_W'(1'b0));
    send_segment(17, FILL_RANDOM, 1'b1);
    settle();

    // longer segments sent without input idling
    send_calm = 1'b1;
    set_config(1'b1, 1'b0, pick_addr(), pick_addr(), pick_addr(), pick_addr());
    send_segment(256, FILL_RANDOM, 1'b1);
    settle();
    set_config(1'b0, 1'b1, pick_addr(), pick_addr(), pick_addr(), pick_addr());
    send_segment(131, FILL_ONES, 1'b1);
    settle();

    // random phases: fresh registers, then a handful of segments
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      settle();
      if ($urandom_range(0, 1)) write_reg(CFG_IP_VERSION_SIX, {$urandom, $urandom});
      if ($urandom_range(0, 1)) write_reg(CFG_TRANSPORT_IS_UDP, {$urandom, $urandom});
      if ($urandom_range(0, 1)) write_reg(CFG_SOURCE_ADDR_HIGH, pick_addr());
      if ($urandom_range(0, 1)) write_reg(CFG_SOURCE_ADDR_LOW, pick_addr());
      if ($urandom_range(0, 1)) write_reg(CFG_DEST_ADDR_HIGH, pick_addr());
      if ($urandom_range(0, 1)) write_reg(CFG_DEST_ADDR_LOW, pick_addr());
      nseg = $urandom_range(3, 8);
      repeat (nseg) begin
        send_calm = ($urandom_range(0, 4) == 0);
        len       = pick_length();
        fill      = pick_fill();
        if (len > 2 && $urandom_range(0, 9) == 0) begin
          // transport changes under a partly sent segment
          cut = $urandom_range(1, len - 1);
          send_segment(cut, fill, 1'b0);
          settle();
          write_reg(CFG_TRANSPORT_IS_UDP, CFG_W'($urandom_range(0, 1)));
          send_segment(len - cut, fill, 1'b1);
        end else begin
          send_segment(len, fill, 1'b1);
        end
      end
    end

    settle();
    repeat (4 * LATENCY) @(posedge clk_i);
    if (fail_count == 0 && pending_results == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/tphc_pkg.sv
hw/rtl/tphc_if.sv
hw/rtl/transport_pseudo_header_checksum_core.sv
bench/tphc_checksum_checker.sv
bench/tb_transport_pseudo_header_checksum_core.sv
